// ----- rtl/ptst_pkg.sv -----
// shared types, codes and constants of the punctuation and string tokenizer
package ptst_pkg;

    // most results that one input item can cause
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // default depth of the queue between front and back
    localparam int DEF_QUEUE_DEPTH = 4;

    // source bytes with a meaning of their own
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // token kinds
    typedef enum logic [4:0] {
        KIND_STRING = 5'd0,
        KIND_DOT    = 5'd1,
        KIND_PLUS   = 5'd2,
        KIND_MINUS  = 5'd3,
        KIND_DIV    = 5'd4,
        KIND_MUL    = 5'd5,
        KIND_LT     = 5'd6,
        KIND_GT     = 5'd7,
        KIND_ASSIGN = 5'd8,
        KIND_EQ     = 5'd9,
        KIND_AND    = 5'd10,
        KIND_OR     = 5'd11,
        KIND_LPAREN = 5'd12,
        KIND_RPAREN = 5'd13,
        KIND_LBRACE = 5'd14,
        KIND_RBRACE = 5'd15,
        KIND_LBRACK = 5'd16,
        KIND_RBRACK = 5'd17,
        KIND_BANG   = 5'd18,
        KIND_END    = 5'd19
    } kind_t;

    // lexer mode
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_STRING = 3'b010,
        MODE_ESCAPE = 3'b100
    } lex_mode_t;

    // operator waiting for its second byte
    typedef enum logic [3:0] {
        PEND_NONE = 4'b0001,
        PEND_EQ   = 4'b0010,
        PEND_AMP  = 4'b0100,
        PEND_BAR  = 4'b1000
    } pend_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       string_done;
        logic       last_of_item;
    } out_item_t;

    // one result before it gets its position mark
    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       string_done;
    } tok_t;

    // all results of one item
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        tok_t [MAX_RES-1:0]        tok;
    } batch_t;

endpackage

// ----- rtl/punctuation_and_string_tokenizer_unit.sv -----
// top level of the punctuation and string tokenizer
//
// Takes source text one byte per item and gives punctuation tokens, '==', '&&'
// and '||', quoted strings as one result per decoded character plus a
// terminator, and an end marker on the end-of-text item. The front end
// accepts one item every cycle while the batch queue (QUEUE_DEPTH items) has
// room; each item's results, from zero up to four, are queued together. The
// back end sends one result per cycle while out_ready is high, through a
// registered output, so an item of k results holds the result port for all k,
// and items of at most one result sustain one item per cycle. The first result
// of an item passes through the batch queue and then the output register.
module punctuation_and_string_tokenizer_unit #(
    parameter int QUEUE_DEPTH = ptst_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptst_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ptst_pkg::out_item_t out_data
);
    import ptst_pkg::*;

    logic   accept;
    logic   push;
    logic   full;
    logic   empty;
    logic   pop;
    batch_t push_batch;
    batch_t head_batch;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // classify items and build batches
    ptst_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .push   (push),
        .batch  (push_batch)
    );

    // decouple front and back
    ptst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_batch),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head_batch)
    );

    // stream results out
    ptst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head_batch),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/ptst_front.sv -----
// front end: accepts bytes, tracks lexer state and builds the result batch of each item
module ptst_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ptst_pkg::in_item_t item,
    output logic               push,
    output ptst_pkg::batch_t   batch
);
    import ptst_pkg::*;

    lex_mode_t mode_reg, mode_next;
    pend_t     pend_reg, pend_next;

    // append one result to a batch
    function automatic batch_t add_tok(batch_t b, kind_t k, logic [7:0] c,
                                       logic has, logic done);
        tok_t t;
        t.token_kind  = k;
        t.char_value  = c;
        t.has_char    = has;
        t.string_done = done;
        if (b.count < CNT_W'(MAX_RES))
        begin
            b.tok[b.count[IDX_W-1:0]] = t;
            b.count = b.count + 1'b1;
        end
        return b;
    endfunction

    // single-byte punctuation, string kind means no token
    function automatic kind_t punct_kind(logic [7:0] c);
        kind_t k;
        k = KIND_STRING;
        if (c == CH_DOT)         k = KIND_DOT;
        else if (c == CH_PLUS)   k = KIND_PLUS;
        else if (c == CH_MINUS)  k = KIND_MINUS;
        else if (c == CH_SLASH)  k = KIND_DIV;
        else if (c == CH_STAR)   k = KIND_MUL;
        else if (c == CH_LT)     k = KIND_LT;
        else if (c == CH_GT)     k = KIND_GT;
        else if (c == CH_LPAREN) k = KIND_LPAREN;
        else if (c == CH_RPAREN) k = KIND_RPAREN;
        else if (c == CH_LBRACE) k = KIND_LBRACE;
        else if (c == CH_RBRACE) k = KIND_RBRACE;
        else if (c == CH_LBRACK) k = KIND_LBRACK;
        else if (c == CH_RBRACK) k = KIND_RBRACK;
        else if (c == CH_BANG)   k = KIND_BANG;
        return k;
    endfunction

    // classify the item against the current state
    always_comb
    begin
        batch_t     b;
        logic       str_byte;
        logic       skip;
        kind_t      k;
        logic [7:0] c;

        b         = '0;
        mode_next = mode_reg;
        pend_next = pend_reg;
        str_byte  = 1'b0;
        skip      = 1'b0;
        k         = KIND_STRING;
        c         = item.ch;

        if (item.ch_valid)
        begin
            if (mode_reg == MODE_ESCAPE)
            begin
                mode_next = MODE_STRING;
                if (c == CH_QUOTE)
                    b = add_tok(b, KIND_STRING, CH_QUOTE, 1'b1, 1'b0);
                else if (c == CH_N)
                    b = add_tok(b, KIND_STRING, CH_NL, 1'b1, 1'b0);
                else
                begin
                    b        = add_tok(b, KIND_STRING, CH_BSLASH, 1'b1, 1'b0);
                    str_byte = 1'b1;
                end
            end
            else if (mode_reg == MODE_STRING)
            begin
                str_byte = 1'b1;
            end
            else
            begin
                // complete a pending operator, emit a lone '=' or drop a lone '&' or '|'
                mode_next = MODE_NORMAL;
                if (pend_reg == PEND_EQ)
                begin
                    pend_next = PEND_NONE;
                    if (c == CH_EQ)
                    begin
                        b    = add_tok(b, KIND_EQ, 8'h00, 1'b0, 1'b0);
                        skip = 1'b1;
                    end
                    else
                        b = add_tok(b, KIND_ASSIGN, 8'h00, 1'b0, 1'b0);
                end
                else if (pend_reg == PEND_AMP)
                begin
                    pend_next = PEND_NONE;
                    if (c == CH_AMP)
                    begin
                        b    = add_tok(b, KIND_AND, 8'h00, 1'b0, 1'b0);
                        skip = 1'b1;
                    end
                end
                else if (pend_reg == PEND_BAR)
                begin
                    pend_next = PEND_NONE;
                    if (c == CH_BAR)
                    begin
                        b    = add_tok(b, KIND_OR, 8'h00, 1'b0, 1'b0);
                        skip = 1'b1;
                    end
                end

                // the byte itself
                if (!skip)
                begin
                    if (c == CH_QUOTE)
                        mode_next = MODE_STRING;
                    else if (c == CH_EQ)
                        pend_next = PEND_EQ;
                    else if (c == CH_AMP)
                        pend_next = PEND_AMP;
                    else if (c == CH_BAR)
                        pend_next = PEND_BAR;
                    else
                    begin
                        k = punct_kind(c);
                        if (k != KIND_STRING)
                            b = add_tok(b, k, 8'h00, 1'b0, 1'b0);
                    end
                end
            end

            // byte inside a string
            if (str_byte)
            begin
                if (c == CH_QUOTE)
                begin
                    b         = add_tok(b, KIND_STRING, 8'h00, 1'b0, 1'b1);
                    mode_next = MODE_NORMAL;
                end
                else if (c == CH_BSLASH)
                    mode_next = MODE_ESCAPE;
                else
                    b = add_tok(b, KIND_STRING, c, 1'b1, 1'b0);
            end
        end

        // end of text flush
        if (item.end_of_text)
        begin
            if (mode_next == MODE_STRING || mode_next == MODE_ESCAPE)
            begin
                if (mode_next == MODE_ESCAPE)
                    b = add_tok(b, KIND_STRING, CH_BSLASH, 1'b1, 1'b0);
                b = add_tok(b, KIND_STRING, 8'h00, 1'b0, 1'b1);
            end
            else if (pend_next == PEND_EQ)
                b = add_tok(b, KIND_ASSIGN, 8'h00, 1'b0, 1'b0);
            b         = add_tok(b, KIND_END, 8'h00, 1'b0, 1'b0);
            mode_next = MODE_NORMAL;
            pend_next = PEND_NONE;
        end

        batch = b;
    end

    assign push = accept && (batch.count != '0);

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            pend_reg <= PEND_NONE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ----- rtl/ptst_queue.sv -----
// short queue of result batches between front and back
module ptst_queue #(
    parameter int DEPTH = ptst_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ptst_pkg::batch_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output ptst_pkg::batch_t head
);
    import ptst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = $clog2(DEPTH + 1);

    batch_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic              do_push, do_pop;

    assign full    = (num_reg == NUM_W'(DEPTH));
    assign empty   = (num_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        num_next    = num_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            num_next = num_reg + 1'b1;
        else if (do_pop && !do_push)
            num_next = num_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            num_reg    <= num_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/ptst_back.sv -----
// back end: walks each batch, one result per unstalled cycle into the output register
module ptst_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  ptst_pkg::batch_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ptst_pkg::out_item_t out_data
);
    import ptst_pkg::*;

    logic [IDX_W-1:0] sub_reg, sub_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             load;
    logic             last;
    tok_t             cur;

    assign load = !empty && (!out_valid_reg || out_ready);
    assign cur  = head.tok[sub_reg];
    assign last = (CNT_W'(sub_reg) + 1'b1 == head.count);
    assign pop  = load && last;

    // next result and position in the batch
    always_comb
    begin
        sub_next       = sub_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_next.token_kind   = cur.token_kind;
            out_next.char_value   = cur.char_value;
            out_next.has_char     = cur.has_char;
            out_next.string_done  = cur.string_done;
            out_next.last_of_item = last;
            out_valid_next        = 1'b1;
            sub_next              = last ? '0 : sub_reg + 1'b1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- bench/punctuation_and_string_tokenizer_unit_test.sv -----
// self-checking bench of the punctuation and string tokenizer unit
`timescale 1ns / 1ps

module punctuation_and_string_tokenizer_unit_test;
    import ptst_pkg::*;

    // one row of the directed text; first is typed in only where typed is set
    typedef struct {
        in_item_t  item;
        bit        typed;
        int        n;
        out_item_t first;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // lexer state of the predictor
    lex_mode_t lex_mode_q;
    pend_t     pend_q;
    out_item_t fresh[$];

    // tokens still owed by the block, oldest first
    out_item_t tokens_due[$];
    row_t      directed[$];
    in_item_t  source_text[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  tokens_seen = 0;
    int  burst_left  = 0;
    bit  send_calm   = 1'b0;
    bit  long_hold_req = 1'b0;

    logic [7:0] marks [14] = '{CH_DOT, CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_LT, CH_GT,
                               CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK,
                               CH_RBRACK, CH_BANG};

    punctuation_and_string_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic out_item_t tok(input kind_t k, input logic [7:0] c, input logic h,
                                      input logic d, input logic l);
        out_item_t t;
        t.token_kind   = k;
        t.char_value   = c;
        t.has_char     = h;
        t.string_done  = d;
        t.last_of_item = l;
        return t;
    endfunction

    function automatic in_item_t text_item(input logic [7:0] c, input logic v, input logic e);
        in_item_t it;
        it.ch          = c;
        it.ch_valid    = v;
        it.end_of_text = e;
        return it;
    endfunction

    function automatic row_t row(input logic [7:0] c, input logic v, input logic e,
                                 input bit typed, input int n, input out_item_t r0);
        row_t r;
        r.item  = text_item(c, v, e);
        r.typed = typed;
        r.n     = n;
        r.first = r0;
        return r;
    endfunction

    // at most four tokens per item
    function automatic void put(input kind_t k, input logic [7:0] c, input logic h,
                                input logic d);
        if (fresh.size() < MAX_RES)
            fresh.push_back(tok(k, c, h, d, 1'b0));
    endfunction

    function automatic bit punct_of(input logic [7:0] c, output kind_t k);
        k = KIND_STRING;
        case (c)
            CH_DOT:    k = KIND_DOT;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_SLASH:  k = KIND_DIV;
            CH_STAR:   k = KIND_MUL;
            CH_LT:     k = KIND_LT;
            CH_GT:     k = KIND_GT;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_BANG:   k = KIND_BANG;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // byte inside an open string
    function automatic void string_char(input logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            put(KIND_STRING, 8'h00, 1'b0, 1'b1);
            lex_mode_q = MODE_NORMAL;
        end
        else if (c == CH_BSLASH)
            lex_mode_q = MODE_ESCAPE;
        else
            put(KIND_STRING, c, 1'b1, 1'b0);
    endfunction

    // byte outside strings, after resolving the waiting operator
    function automatic void plain_char(input logic [7:0] c);
        kind_t k;
        pend_t was;
        was    = pend_q;
        pend_q = PEND_NONE;
        case (was)
            PEND_EQ:
            begin
                if (c == CH_EQ)
                begin
                    put(KIND_EQ, 8'h00, 1'b0, 1'b0);
                    return;
                end
                put(KIND_ASSIGN, 8'h00, 1'b0, 1'b0);
            end
            PEND_AMP:
            begin
                if (c == CH_AMP)
                begin
                    put(KIND_AND, 8'h00, 1'b0, 1'b0);
                    return;
                end
            end
            PEND_BAR:
            begin
                if (c == CH_BAR)
                begin
                    put(KIND_OR, 8'h00, 1'b0, 1'b0);
                    return;
                end
            end
            default: ;
        endcase
        if (c == CH_QUOTE)
            lex_mode_q = MODE_STRING;
        else if (c == CH_EQ)
            pend_q = PEND_EQ;
        else if (c == CH_AMP)
            pend_q = PEND_AMP;
        else if (c == CH_BAR)
            pend_q = PEND_BAR;
        else if (punct_of(c, k))
            put(k, 8'h00, 1'b0, 1'b0);
    endfunction

    // tokens of one accepted item, left in fresh
    function automatic void lex_step(input in_item_t it);
        fresh.delete();
        if (it.ch_valid)
        begin
            case (lex_mode_q)
                MODE_STRING: string_char(it.ch);
                MODE_ESCAPE:
                begin
                    lex_mode_q = MODE_STRING;
                    if (it.ch == CH_QUOTE)
                        put(KIND_STRING, CH_QUOTE, 1'b1, 1'b0);
                    else if (it.ch == CH_N)
                        put(KIND_STRING, CH_NL, 1'b1, 1'b0);
                    else
                    begin
                        put(KIND_STRING, CH_BSLASH, 1'b1, 1'b0);
                        string_char(it.ch);
                    end
                end
                default:
                begin
                    lex_mode_q = MODE_NORMAL;
                    plain_char(it.ch);
                end
            endcase
        end
        // end of text flushes lookahead and any open string
        if (it.end_of_text)
        begin
            if (lex_mode_q != MODE_NORMAL)
            begin
                if (lex_mode_q == MODE_ESCAPE)
                    put(KIND_STRING, CH_BSLASH, 1'b1, 1'b0);
                put(KIND_STRING, 8'h00, 1'b0, 1'b1);
            end
            else if (pend_q == PEND_EQ)
                put(KIND_ASSIGN, 8'h00, 1'b0, 1'b0);
            put(KIND_END, 8'h00, 1'b0, 1'b0);
            lex_mode_q = MODE_NORMAL;
            pend_q     = PEND_NONE;
        end
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last_of_item = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // offer one item after a random gap and record what it should cause
    task automatic offer(input in_item_t it, input bit typed, input int n,
                         input out_item_t r0);
        int gap;
        if (items_sent % 16 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        gap = (send_calm || burst_left > 0) ? 0 : $urandom_range(0, 11);
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        lex_step(it);
        if (typed)
        begin
            if (n > 0)
                tokens_due.push_back(r0);
        end
        else
            foreach (fresh[i]) tokens_due.push_back(fresh[i]);
    endtask

    // result side: random stalls, one long hold when asked
    initial
    begin
        int gap;
        int k;
        out_ready = 1'b0;
        k = 0;
        @(posedge rst_n);
        forever
        begin
            if (k % 16 == 0)
                gap = ($urandom_range(0, 3) == 0) ? -1 : 0;
            if (long_hold_req)
            begin
                gap = 48;
                long_hold_req = 1'b0;
            end
            else if (gap >= 0 && gap != 48)
                gap = $urandom_range(0, 11);
            else if (gap == 48)
                gap = $urandom_range(0, 11);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            k++;
        end
    end

    // compare each accepted token with the oldest one owed
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            tokens_seen++;
            if (tokens_due.size() == 0)
                report_mismatch("token with none owed, kind", out_data.token_kind, 0);
            else
            begin
                want = tokens_due.pop_front();
                if (out_data.token_kind !== want.token_kind)
                    report_mismatch("token_kind", out_data.token_kind, want.token_kind);
                if (out_data.char_value !== want.char_value)
                    report_mismatch("char_value", out_data.char_value, want.char_value);
                if (out_data.has_char !== want.has_char)
                    report_mismatch("has_char", out_data.has_char, want.has_char);
                if (out_data.string_done !== want.string_done)
                    report_mismatch("string_done", out_data.string_done, want.string_done);
                if (out_data.last_of_item !== want.last_of_item)
                    report_mismatch("last_of_item", out_data.last_of_item,
                                    want.last_of_item);
            end
        end
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [7:0] c;
        int len;
        int pick;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        lex_mode_q = MODE_NORMAL;
        pend_q     = PEND_NONE;

        // directed text: operators, pairs, escapes and flushes
        directed.push_back(row(CH_DOT, 1, 0, 1, 1, tok(KIND_DOT, 8'h00, 0, 0, 1)));
        directed.push_back(row(CH_EQ, 1, 0, 1, 0, '0));
        directed.push_back(row(CH_EQ, 1, 0, 1, 1, tok(KIND_EQ, 8'h00, 0, 0, 1)));
        directed.push_back(row(CH_EQ, 1, 0, 1, 0, '0));
        directed.push_back(row(CH_PLUS, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_AMP, 1, 0, 1, 0, '0));
        directed.push_back(row(CH_AMP, 1, 0, 1, 1, tok(KIND_AND, 8'h00, 0, 0, 1)));
        directed.push_back(row(CH_AMP, 1, 0, 1, 0, '0));
        directed.push_back(row(CH_BAR, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_BAR, 1, 0, 1, 1, tok(KIND_OR, 8'h00, 0, 0, 1)));
        directed.push_back(row(CH_BAR, 1, 0, 1, 0, '0));
        directed.push_back(row(8'hFF, 1, 0, 0, 0, '0));
        directed.push_back(row(8'hFF, 0, 0, 1, 0, '0));
        directed.push_back(row(CH_QUOTE, 1, 0, 1, 0, '0));
        directed.push_back(row(8'h00, 1, 0, 0, 0, '0));
        directed.push_back(row(8'hFF, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_BSLASH, 1, 0, 1, 0, '0));
        directed.push_back(row(CH_N, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_BSLASH, 1, 0, 1, 0, '0));
        // backslash after backslash: unknown escape that opens a new one
        directed.push_back(row(CH_BSLASH, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_QUOTE, 1, 0, 0, 0, '0));
        directed.push_back(row(CH_BSLASH, 1, 0, 1, 0, '0));
        // 'x' with end of text: four tokens from one item
        directed.push_back(row(8'h78, 1, 1, 0, 0, '0));
        directed.push_back(row(CH_EQ, 1, 1, 0, 0, '0));
        directed.push_back(row(8'h00, 0, 1, 1, 1, tok(KIND_END, 8'h00, 0, 0, 1)));
        directed.push_back(row(CH_QUOTE, 1, 0, 0, 0, '0));
        directed.push_back(row(8'hA5, 0, 1, 0, 0, '0));

        // random text, mostly well-formed fragments with random content
        while (source_text.size() < 153)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: source_text.push_back(text_item(marks[$urandom_range(0, 13)], 1, 0));
                2:
                begin
                    source_text.push_back(text_item(CH_EQ, 1, 0));
                    if ($urandom_range(0, 1))
                        source_text.push_back(text_item(CH_EQ, 1, 0));
                end
                3:
                begin
                    c = $urandom_range(0, 1) ? CH_AMP : CH_BAR;
                    source_text.push_back(text_item(c, 1, 0));
                    if ($urandom_range(0, 2) != 0)
                        source_text.push_back(text_item(c, 1, 0));
                end
                4, 5:
                begin
                    source_text.push_back(text_item(CH_QUOTE, 1, 0));
                    len = $urandom_range(0, 6);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            source_text.push_back(text_item(CH_BSLASH, 1, 0));
                            case ($urandom_range(0, 2))
                                0:       c = CH_N;
                                1:       c = CH_QUOTE;
                                default: c = 8'($urandom_range(0, 255));
                            endcase
                        end
                        else
                            c = 8'($urandom_range(0, 255));
                        source_text.push_back(text_item(c, 1, 0));
                    end
                    if ($urandom_range(0, 7) != 0)
                        source_text.push_back(text_item(CH_QUOTE, 1, 0));
                end
                6: source_text.push_back(text_item(8'($urandom_range(0, 255)),
                                                   1'($urandom_range(0, 1)), 1));
                7, 8: source_text.push_back(text_item(8'($urandom_range(0, 255)), 1, 0));
                default: source_text.push_back(text_item(8'($urandom_range(0, 255)),
                                                         1'($urandom_range(0, 1)),
                                                         $urandom_range(0, 5) == 0));
            endcase
        end

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer(directed[i].item, directed[i].typed, directed[i].n, directed[i].first);

        // back-to-back items against a long result stall
        long_hold_req = 1'b1;
        burst_left    = 30;
        foreach (source_text[i])
        begin
            if (i == source_text.size() / 2)
            begin
                // sender waits until the block has drained
                @(negedge clk);
                in_valid <= 1'b0;
                while (tokens_due.size() != 0) @(posedge clk);
            end
            offer(source_text[i], 1'b0, 0, '0);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d text items and %0d tokens: punctuation, operator pairs,",
                 items_sent, tokens_seen);
        $display("strings with escapes, flushes at end of text, and long stalls on both sides");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
